// ===== src/line_sensor_normalize_smooth_assert.svh =====
// assertion macros for the line sensor normaliser
// used by the top level only; no other dependencies
`ifndef LINE_SENSOR_NORMALIZE_SMOOTH_ASSERT_SVH
`define LINE_SENSOR_NORMALIZE_SMOOTH_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define LSNS_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lsns check failed");

// condition holds in the cycle after the trigger
`define LSNS_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lsns check failed");

`endif

// ===== src/lsns_pkg.sv =====
// shared constants, types and register codes for the line sensor normaliser
// no dependencies
`timescale 1ns / 1ps

package lsns_pkg;

  // channel count and lane layout
  localparam int CHANNELS  = 4;
  localparam int LANES     = 4;
  localparam int ACTIVE_CH = (CHANNELS < LANES) ? CHANNELS : LANES;
  localparam int CH_W      = $clog2(LANES);

  // field widths
  localparam int RAW_W   = 8;
  localparam int LEVEL_W = 10;
  localparam int AVG_W   = 26;
  localparam int ALPHA_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // normalisation and divider sizing
  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1000);
  localparam int NUM_W       = RAW_W + LEVEL_W;
  localparam int QUO_W       = LEVEL_W;
  localparam int DIV_STEPS   = QUO_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // smoothing arithmetic
  localparam int WEIGHT_W    = ALPHA_W + 1;
  localparam int PROD_A_W    = ALPHA_W + AVG_W;
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_MIN = 2'd0,
    REG_CAL_MAX = 2'd1,
    REG_ALPHA   = 2'd2
  } cfg_reg_t;

  // divider request and status
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [RAW_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic last;
  } div_stat_t;

  // smoothing unit request
  typedef struct packed {
    logic               load;
    logic [ALPHA_W-1:0] alpha;
    logic [LEVEL_W-1:0] norm;
  } ema_req_t;

endpackage

// ===== src/lsns_if.sv =====
// valid/ready channel interfaces for sample words and result words
// depends on lsns_pkg
`timescale 1ns / 1ps

interface lsns_sample_if;
  logic                       valid;
  logic                       ready;
  logic [lsns_pkg::RAW_W-1:0] sample_ch0;
  logic [lsns_pkg::RAW_W-1:0] sample_ch1;
  logic [lsns_pkg::RAW_W-1:0] sample_ch2;
  logic [lsns_pkg::RAW_W-1:0] sample_ch3;
  logic                       read_ok;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, read_ok,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, read_ok,
                output ready);
endinterface

interface lsns_result_if;
  logic                         valid;
  logic                         ready;
  logic [lsns_pkg::RAW_W-1:0]   echo_ch0;
  logic [lsns_pkg::RAW_W-1:0]   echo_ch1;
  logic [lsns_pkg::RAW_W-1:0]   echo_ch2;
  logic [lsns_pkg::RAW_W-1:0]   echo_ch3;
  logic [lsns_pkg::LEVEL_W-1:0] level_ch0;
  logic [lsns_pkg::LEVEL_W-1:0] level_ch1;
  logic [lsns_pkg::LEVEL_W-1:0] level_ch2;
  logic [lsns_pkg::LEVEL_W-1:0] level_ch3;
  logic                         fresh;

  modport source (output valid, echo_ch0, echo_ch1, echo_ch2, echo_ch3,
                  level_ch0, level_ch1, level_ch2, level_ch3, fresh,
                  input ready);
  modport sink (input valid, echo_ch0, echo_ch1, echo_ch2, echo_ch3,
                level_ch0, level_ch1, level_ch2, level_ch3, fresh,
                output ready);
endinterface

// ===== src/lsns_avg_ram.sv =====
// per-channel moving average store, one read and one write port, registered read
// depends on lsns_pkg
`timescale 1ns / 1ps

module lsns_avg_ram (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [lsns_pkg::CH_W-1:0]      rd_addr,
  output logic [lsns_pkg::AVG_W-1:0]     rd_data,
  input  logic                           wr_en,
  input  logic [lsns_pkg::CH_W-1:0]      wr_addr,
  input  logic [lsns_pkg::AVG_W-1:0]     wr_data
);

  logic [lsns_pkg::AVG_W-1:0] mem [lsns_pkg::LANES];
  logic [lsns_pkg::LANES-1:0] written;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // registered read with write forwarding on the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (written[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ===== src/lsns_div.sv =====
// iterative restoring divider, two quotient bits per cycle
// depends on lsns_pkg
`timescale 1ns / 1ps

module lsns_div (
  input  logic                        clk,
  input  logic                        rst,
  input  lsns_pkg::div_req_t          req,
  output lsns_pkg::div_stat_t         stat,
  output logic [lsns_pkg::QUO_W-1:0]  quotient
);

  logic [lsns_pkg::RAW_W-1:0]     rem;
  logic [lsns_pkg::RAW_W-1:0]     divisor;
  logic [lsns_pkg::QUO_W-1:0]     bits;
  logic [lsns_pkg::DIV_CNT_W-1:0] count;

  logic [lsns_pkg::RAW_W:0]   trial_a;
  logic [lsns_pkg::RAW_W:0]   trial_b;
  logic [lsns_pkg::RAW_W-1:0] rem_a;
  logic [lsns_pkg::RAW_W-1:0] rem_next;
  logic                       q_a;
  logic                       q_b;

  // two compare-subtract steps on the partial remainder
  always_comb begin
    trial_a = {rem, bits[lsns_pkg::QUO_W-1]};
    q_a     = (trial_a >= {1'b0, divisor});
    rem_a   = q_a ? lsns_pkg::RAW_W'(trial_a - {1'b0, divisor})
                  : trial_a[lsns_pkg::RAW_W-1:0];
    trial_b = {rem_a, bits[lsns_pkg::QUO_W-2]};
    q_b     = (trial_b >= {1'b0, divisor});
    rem_next = q_b ? lsns_pkg::RAW_W'(trial_b - {1'b0, divisor})
                   : trial_b[lsns_pkg::RAW_W-1:0];
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.start) begin
      count <= lsns_pkg::DIV_CNT_W'(lsns_pkg::DIV_STEPS);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  // datapath; quotient below 1024 so the top numerator bits seed the remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= req.numer[lsns_pkg::NUM_W-1 -: lsns_pkg::RAW_W];
      bits     <= req.numer[lsns_pkg::QUO_W-1:0];
      divisor  <= req.denom;
    end else if (count != '0) begin
      rem      <= rem_next;
      bits     <= {bits[lsns_pkg::QUO_W-3:0], 2'b00};
      quotient <= {quotient[lsns_pkg::QUO_W-3:0], q_a, q_b};
    end
  end

  assign stat.busy = (count != '0);
  assign stat.last = (count == lsns_pkg::DIV_CNT_W'(1));

endmodule

// ===== src/lsns_ema.sv =====
// moving average update: product stage then floor, add and clamp
// depends on lsns_pkg
`timescale 1ns / 1ps

module lsns_ema (
  input  logic                          clk,
  input  lsns_pkg::ema_req_t            req,
  input  logic [lsns_pkg::AVG_W-1:0]    avg_old,
  output logic [lsns_pkg::AVG_W-1:0]    avg_next,
  output logic [lsns_pkg::LEVEL_W-1:0]  level
);

  logic [lsns_pkg::PROD_A_W-1:0] prod_a;
  logic [lsns_pkg::AVG_W-1:0]    prod_b;
  logic [lsns_pkg::WEIGHT_W-1:0] weight_new;
  logic [lsns_pkg::LEVEL_W-1:0]  avg_int;

  assign weight_new = lsns_pkg::ONE_Q16 - lsns_pkg::WEIGHT_W'(req.alpha);

  // old average weighted by alpha, new level by the complement (already in Q16)
  always_ff @(posedge clk) begin
    if (req.load) begin
      prod_a <= lsns_pkg::PROD_A_W'(req.alpha) * lsns_pkg::PROD_A_W'(avg_old);
      prod_b <= lsns_pkg::AVG_W'(weight_new) * lsns_pkg::AVG_W'(req.norm);
    end
  end

  // floor of the weighted sum, wrapped to Q10.16
  assign avg_next = prod_a[lsns_pkg::PROD_A_W-1 -: lsns_pkg::AVG_W] + prod_b;
  assign avg_int  = avg_next[lsns_pkg::AVG_W-1 -: lsns_pkg::LEVEL_W];
  assign level    = (avg_int > lsns_pkg::FULL_SCALE) ? lsns_pkg::FULL_SCALE : avg_int;

endmodule

// ===== src/line_sensor_normalize_smooth.sv =====
// line sensor min/max normaliser with per-channel moving average
// sequence: on a good read each channel passes through read, divide, multiply and accumulate
//   states before output; a failed read goes straight to output. No new word is taken until
//   the sequencer is back in idle, after the previous result is loaded into the output register
// reset: calibration to full range, alpha 0, cached levels and averages read as zero
// depends on lsns_pkg, lsns_if, lsns_avg_ram, lsns_div, lsns_ema
`timescale 1ns / 1ps
`include "line_sensor_normalize_smooth_assert.svh"

module line_sensor_normalize_smooth (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lsns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsns_pkg::CFG_DATA_W-1:0]   cfg_data,
  lsns_sample_if.sink                       sample,
  lsns_result_if.source                     result
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [lsns_pkg::CFG_DATA_W-1:0] cal_min;
  logic [lsns_pkg::CFG_DATA_W-1:0] cal_max;
  logic [lsns_pkg::ALPHA_W-1:0]    alpha;

  logic [lsns_pkg::CH_W-1:0]    ch;
  logic [lsns_pkg::RAW_W-1:0]   raw_q [lsns_pkg::LANES];
  logic                         fresh_q;
  logic [lsns_pkg::LEVEL_W-1:0] norm_q;

  logic [lsns_pkg::RAW_W-1:0]   cached_raw   [lsns_pkg::LANES];
  logic [lsns_pkg::LEVEL_W-1:0] cached_level [lsns_pkg::LANES];

  logic                         out_valid;
  logic [lsns_pkg::RAW_W-1:0]   out_echo  [lsns_pkg::LANES];
  logic [lsns_pkg::LEVEL_W-1:0] out_level [lsns_pkg::LANES];
  logic                         out_fresh;

  logic                         in_take;
  logic                         out_load;
  logic                         last_ch;
  logic                         alpha_on;
  logic [lsns_pkg::RAW_W-1:0]   raw_cur;
  logic [lsns_pkg::RAW_W-1:0]   mn_cur;
  logic [lsns_pkg::RAW_W-1:0]   mx_cur;
  logic [lsns_pkg::RAW_W-1:0]   diff;
  logic [lsns_pkg::LEVEL_W-1:0] norm_sel;

  lsns_pkg::div_req_t           div_req;
  lsns_pkg::div_stat_t          div_stat;
  logic [lsns_pkg::QUO_W-1:0]   div_quo;
  lsns_pkg::ema_req_t           ema_req;
  logic [lsns_pkg::AVG_W-1:0]   avg_rd;
  logic [lsns_pkg::AVG_W-1:0]   avg_next;
  logic [lsns_pkg::LEVEL_W-1:0] ema_level;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_min <= '0;
      cal_max <= '1;
      alpha   <= '0;
    end else if (cfg_write) begin
      case (lsns_pkg::cfg_reg_t'(cfg_index))
        lsns_pkg::REG_CAL_MIN: cal_min <= cfg_data;
        lsns_pkg::REG_CAL_MAX: cal_max <= cfg_data;
        lsns_pkg::REG_ALPHA:   alpha   <= cfg_data[lsns_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_take      = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);
  assign out_load     = (state == ST_OUT) && (!out_valid || result.ready);
  assign last_ch      = (ch == lsns_pkg::CH_W'(lsns_pkg::ACTIVE_CH - 1));
  assign alpha_on     = (alpha != '0);

  // current channel operands
  assign raw_cur = raw_q[ch];
  assign mn_cur  = cal_min[ch * lsns_pkg::RAW_W +: lsns_pkg::RAW_W];
  assign mx_cur  = cal_max[ch * lsns_pkg::RAW_W +: lsns_pkg::RAW_W];
  assign diff    = raw_cur - mn_cur;

  // divider launch: (raw - min) * 1000 / (max - min)
  assign div_req.start = (state == ST_RD);
  assign div_req.numer = lsns_pkg::NUM_W'(diff) * lsns_pkg::NUM_W'(lsns_pkg::FULL_SCALE);
  assign div_req.denom = mx_cur - mn_cur;

  // bounds override the quotient
  always_comb begin
    if (raw_cur <= mn_cur) begin
      norm_sel = '0;
    end else if (raw_cur >= mx_cur) begin
      norm_sel = lsns_pkg::FULL_SCALE;
    end else begin
      norm_sel = div_quo;
    end
  end

  assign ema_req.load  = (state == ST_MUL);
  assign ema_req.alpha = alpha;
  assign ema_req.norm  = norm_sel;

  lsns_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  lsns_avg_ram u_avg_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == ST_RD),
    .rd_addr (ch),
    .rd_data (avg_rd),
    .wr_en   ((state == ST_ACC) && alpha_on),
    .wr_addr (ch),
    .wr_data (avg_next)
  );

  lsns_ema u_ema (
    .clk      (clk),
    .req      (ema_req),
    .avg_old  (avg_rd),
    .avg_next (avg_next),
    .level    (ema_level)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_take) state_next = sample.read_ok ? ST_RD : ST_OUT;
      ST_RD:   state_next = ST_DIV;
      ST_DIV:  if (div_stat.last) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = last_ch ? ST_OUT : ST_RD;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      if (in_take) begin
        ch <= '0;
      end else if ((state == ST_ACC) && !last_ch) begin
        ch <= ch + 1'b1;
      end
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_q[0] <= sample.sample_ch0;
      raw_q[1] <= sample.sample_ch1;
      raw_q[2] <= sample.sample_ch2;
      raw_q[3] <= sample.sample_ch3;
      fresh_q  <= sample.read_ok;
    end
    if (state == ST_MUL) begin
      norm_q <= norm_sel;
    end
  end

  // cached readings, updated one channel per pass
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lsns_pkg::LANES; i++) begin
        cached_raw[i]   <= '0;
        cached_level[i] <= '0;
      end
    end else if (state == ST_ACC) begin
      cached_raw[ch]   <= raw_cur;
      cached_level[ch] <= alpha_on ? ema_level : norm_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < lsns_pkg::LANES; i++) begin
        out_echo[i]  <= cached_raw[i];
        out_level[i] <= cached_level[i];
      end
      out_fresh <= fresh_q;
    end
  end

  assign result.valid     = out_valid;
  assign result.echo_ch0  = out_echo[0];
  assign result.echo_ch1  = out_echo[1];
  assign result.echo_ch2  = out_echo[2];
  assign result.echo_ch3  = out_echo[3];
  assign result.level_ch0 = out_level[0];
  assign result.level_ch1 = out_level[1];
  assign result.level_ch2 = out_level[2];
  assign result.level_ch3 = out_level[3];
  assign result.fresh     = out_fresh;

  // checks
  `LSNS_ASSERT_NEXT(a_fail_skips_work, clk, rst, in_take && !sample.read_ok, state == ST_OUT)
  `LSNS_ASSERT_NEXT(a_ok_starts_ch0, clk, rst, in_take && sample.read_ok, (state == ST_RD) && (ch == '0))
  `LSNS_ASSERT_NOW(a_div_quiet_idle, clk, rst, state == ST_IDLE, !div_stat.busy)
  `LSNS_ASSERT_NOW(a_level_range, clk, rst, result.valid, (result.level_ch0 <= lsns_pkg::FULL_SCALE) && (result.level_ch1 <= lsns_pkg::FULL_SCALE) && (result.level_ch2 <= lsns_pkg::FULL_SCALE) && (result.level_ch3 <= lsns_pkg::FULL_SCALE))

endmodule
